// ===== hdl/row_softmax_core_macros.svh =====
// ----------------------------------------------------------------------------
// row_softmax_core_macros
// Assertion macros shared by the row softmax core.
// ----------------------------------------------------------------------------
`ifndef ROW_SOFTMAX_CORE_MACROS_SVH
`define ROW_SOFTMAX_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RSM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsm_pkg
// Types, constants and the base-2 table of the row softmax core.
// ----------------------------------------------------------------------------
package rsm_pkg;

    localparam int RSM_ROW_LEN     = 64;
    localparam int RSM_STORE_DEPTH = 64;
    localparam int RSM_CNT_W       = 7;
    localparam int RSM_ADDR_W      = 6;
    localparam int RSM_SUM_W       = 22;
    localparam logic [16:0] RSM_LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] RSM_ONE_Q15   = 16'd32768;

    // Command handed from the front to the back through the queue.
    typedef struct packed {
        logic [RSM_CNT_W-1:0] count;
        logic signed [15:0]   row_max;
        logic                 trunc;
    } t_row_cmd;

    function automatic logic [15:0] rsm_pow2_frac(input logic [4:0] idx);
        logic [15:0] v;
        unique case (idx)
            5'd0:  v = 16'd32768;  5'd1:  v = 16'd32066;
            5'd2:  v = 16'd31379;  5'd3:  v = 16'd30706;
            5'd4:  v = 16'd30048;  5'd5:  v = 16'd29405;
            5'd6:  v = 16'd28774;  5'd7:  v = 16'd28158;
            5'd8:  v = 16'd27554;  5'd9:  v = 16'd26964;
            5'd10: v = 16'd26386;  5'd11: v = 16'd25821;
            5'd12: v = 16'd25268;  5'd13: v = 16'd24726;
            5'd14: v = 16'd24196;  5'd15: v = 16'd23678;
            5'd16: v = 16'd23170;  5'd17: v = 16'd22674;
            5'd18: v = 16'd22188;  5'd19: v = 16'd21713;
            5'd20: v = 16'd21248;  5'd21: v = 16'd20792;
            5'd22: v = 16'd20347;  5'd23: v = 16'd19910;
            5'd24: v = 16'd19484;  5'd25: v = 16'd19067;
            5'd26: v = 16'd18658;  5'd27: v = 16'd18258;
            5'd28: v = 16'd17867;  5'd29: v = 16'd17484;
            5'd30: v = 16'd17109;  default: v = 16'd16742;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/rsm_front.sv =====
// ----------------------------------------------------------------------------
// rsm_front
// Accepts logits, writes them to a bank of the row store, tracks the row
// maximum and the truncation flag, and issues a row command at the row end.
// ----------------------------------------------------------------------------
module rsm_front import rsm_pkg::*; #(
    parameter int ROW_LEN = RSM_ROW_LEN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [15:0]    i_logit,
    input  logic                  i_row_end,
    output logic                  o_wr_en,
    output logic                  o_wr_bank,
    output logic [RSM_ADDR_W-1:0] o_wr_addr,
    output logic [15:0]           o_wr_data,
    input  logic                  i_bank_free,
    output logic                  o_cmd_valid,
    output t_row_cmd              o_cmd,
    input  logic                  i_cmd_ready
);

    logic [RSM_CNT_W-1:0] r_count, n_count;
    logic signed [15:0]   r_max, n_max;
    logic                 r_trunc, n_trunc;
    logic                 r_bank;
    logic                 w_acc, w_store;

    assign o_ready  = i_bank_free && i_cmd_ready;
    assign w_acc    = i_valid && o_ready;
    assign w_store  = r_count < RSM_CNT_W'(ROW_LEN);

    assign o_wr_en   = w_acc && w_store;
    assign o_wr_bank = r_bank;
    assign o_wr_addr = r_count[RSM_ADDR_W-1:0];
    assign o_wr_data = i_logit;

    always_comb begin
        n_count = r_count;
        n_max   = r_max;
        n_trunc = r_trunc;
        if (w_store) begin
            n_count = r_count + 1'b1;
            if (i_logit > r_max) begin
                n_max = i_logit;
            end
        end else begin
            n_trunc = 1'b1;
        end
    end

    assign o_cmd_valid   = w_acc && i_row_end;
    assign o_cmd.count   = n_count;
    assign o_cmd.row_max = n_max;
    assign o_cmd.trunc   = n_trunc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_max   <= 16'sh8000;
            r_trunc <= 1'b0;
            r_bank  <= 1'b0;
        end else if (w_acc) begin
            if (i_row_end) begin
                r_count <= '0;
                r_max   <= 16'sh8000;
                r_trunc <= 1'b0;
                r_bank  <= ~r_bank;
            end else begin
                r_count <= n_count;
                r_max   <= n_max;
                r_trunc <= n_trunc;
            end
        end
    end

endmodule

// ===== hdl/rsm_queue.sv =====
// ----------------------------------------------------------------------------
// rsm_queue
// Two-entry queue of row commands between the front and the back.
// ----------------------------------------------------------------------------
module rsm_queue import rsm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_row_cmd i_cmd,
    output logic     o_ready,
    output logic     o_valid,
    output t_row_cmd o_cmd,
    input  logic     i_ready
);

    t_row_cmd r_mem [2];
    logic     r_wp, r_rp;
    logic [1:0] r_cnt;
    logic     w_push, w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== hdl/rsm_back.sv =====
// ----------------------------------------------------------------------------
// rsm_back
// Holds the two-bank row store. For each row command it replays the row to
// form the exponent sum, then replays it again and divides each exponent by
// the sum with a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsm_back import rsm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic                  i_wr_bank,
    input  logic [RSM_ADDR_W-1:0] i_wr_addr,
    input  logic [15:0]           i_wr_data,
    output logic                  o_bank_free,
    input  logic                  i_cmd_valid,
    input  t_row_cmd              i_cmd,
    output logic                  o_cmd_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [15:0]           o_prob,
    output logic                  o_last,
    output logic                  o_trunc
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EXP  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam int NUM_W = 31;
    localparam int REM_W = RSM_SUM_W + 1;

    logic [15:0] r_mem [2*RSM_STORE_DEPTH];
    logic [15:0] r_rd;

    logic [2:0]           r_st;
    logic                 r_bank;
    t_row_cmd             r_cmd;
    logic [RSM_CNT_W-1:0] r_idx;
    logic                 r_rd_ok;
    logic [RSM_SUM_W-1:0] r_sum;
    logic [NUM_W-1:0]     r_num;
    logic [REM_W-1:0]     r_rem;
    logic [4:0]           r_bit;
    logic [15:0]          r_q;
    logic [15:0]          r_prob;
    logic                 r_last, r_trunc, r_ov;
    logic [15:0]          r_e;

    logic [15:0] w_d;
    logic [32:0] w_t;
    logic [15:0] w_e;
    logic [REM_W-1:0] w_shift;
    logic        w_fin;
    logic        w_load;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[{i_wr_bank, i_wr_addr}] <= i_wr_data;
        end
        r_rd <= r_mem[{r_bank, r_idx[RSM_ADDR_W-1:0]}];
    end

    // The oldest unfinished row sits in r_bank. The front may fill its bank
    // unless that bank still holds a row that has not been fully replayed.
    assign o_bank_free = (i_wr_bank != r_bank) || (r_st == S_IDLE && !i_cmd_valid);
    assign o_cmd_ready = r_st == S_IDLE;

    assign w_d = 16'(r_cmd.row_max - $signed(r_rd));
    assign w_t = {17'd0, w_d} * {16'd0, RSM_LOG2E_Q16};
    assign w_e = (w_t[32:28] != 5'd0) ? 16'd0 : (rsm_pow2_frac(w_t[23:19]) >> w_t[27:24]);
    assign w_shift = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign w_fin = r_idx + 1'b1 == r_cmd.count;
    assign w_load = (r_st == S_OUT) && (!r_ov || i_ready);

    assign o_valid = r_ov;
    assign o_prob  = r_prob;
    assign o_last  = r_last;
    assign o_trunc = r_trunc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_bank <= 1'b0;
            r_ov   <= 1'b0;
            r_idx  <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_sum   <= '0;
                        r_rd_ok <= 1'b0;
                        r_st    <= S_SUM;
                    end
                end
                S_SUM: begin
                    // Read data is registered, so it arrives in the cycle after its address.
                    if (r_rd_ok) begin
                        r_sum <= r_sum + RSM_SUM_W'(r_e);
                    end
                    r_rd_ok <= 1'b0;
                    r_st    <= S_EXP;
                end
                S_EXP: begin
                    r_e <= w_e;
                    if (w_fin) begin
                        r_sum   <= r_sum + RSM_SUM_W'(w_e);
                        r_idx   <= '0;
                        r_rd_ok <= 1'b0;
                        r_st    <= S_RD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_rd_ok <= 1'b1;
                        r_st    <= S_SUM;
                    end
                end
                S_RD: begin
                    if (!r_rd_ok) begin
                        r_rd_ok <= 1'b1;
                    end else begin
                        r_num <= NUM_W'({w_e, 15'd0}) + NUM_W'(r_sum >> 1);
                        r_rem <= '0;
                        r_bit <= '0;
                        r_st  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_shift >= {1'b0, r_sum}) begin
                        r_rem <= w_shift - {1'b0, r_sum};
                        r_q   <= {r_q[14:0], 1'b1};
                    end else begin
                        r_rem <= w_shift;
                        r_q   <= {r_q[14:0], 1'b0};
                    end
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == 5'(NUM_W-1)) begin
                        r_st <= S_OUT;
                    end
                end
                default: begin
                    if (w_load) begin
                        r_prob  <= r_q;
                        r_last  <= w_fin;
                        r_trunc <= r_cmd.trunc;
                        if (w_fin) begin
                            r_bank <= ~r_bank;
                            r_st   <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_rd_ok <= 1'b0;
                            r_st    <= S_RD;
                        end
                    end
                end
            endcase
        end
    end

endmodule

// ===== hdl/row_softmax_core.sv =====
// A row's first probability appears once the back part has replayed the
// row to form the exponent sum; later ones each wait on the
// one-bit-per-cycle divider in the back part, plus output stalls.
// Logits load at one per cycle into a free bank of a two-bank store; input
// stalls while both banks hold rows that are still being replayed.
// Reset is synchronous and active low and clears all control state.
// ----------------------------------------------------------------------------
// row_softmax_core
// Max-subtracted softmax over one row of Q8.8 logits, Q1.15 results.
// ----------------------------------------------------------------------------
module row_softmax_core import rsm_pkg::*; #(
    parameter int ROW_LEN = RSM_ROW_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // logit
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // prob
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // truncated
);

`include "row_softmax_core_macros.svh"

    logic                  w_wr_en, w_wr_bank, w_bank_free;
    logic [RSM_ADDR_W-1:0] w_wr_addr;
    logic [15:0]           w_wr_data;
    logic                  w_fc_valid, w_fc_ready, w_qb_valid, w_qb_ready;
    t_row_cmd              w_fc, w_qb;

    rsm_front #(.ROW_LEN(ROW_LEN)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_logit(s_axis_tdata), .i_row_end(s_axis_tlast),
        .o_wr_en(w_wr_en), .o_wr_bank(w_wr_bank), .o_wr_addr(w_wr_addr),
        .o_wr_data(w_wr_data), .i_bank_free(w_bank_free),
        .o_cmd_valid(w_fc_valid), .o_cmd(w_fc), .i_cmd_ready(w_fc_ready)
    );

    rsm_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fc_valid), .i_cmd(w_fc), .o_ready(w_fc_ready),
        .o_valid(w_qb_valid), .o_cmd(w_qb), .i_ready(w_qb_ready)
    );

    rsm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_en(w_wr_en), .i_wr_bank(w_wr_bank), .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data), .o_bank_free(w_bank_free),
        .i_cmd_valid(w_qb_valid), .i_cmd(w_qb), .o_cmd_ready(w_qb_ready),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_prob(m_axis_tdata), .o_last(m_axis_tlast), .o_trunc(m_axis_tuser)
    );

    `RSM_ASSERT_IMPL(a_prob_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata <= RSM_ONE_Q15, "probability above one")
    `RSM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `RSM_ASSERT_IMPL(a_wr_bound, i_clk, i_rst_n, w_wr_en, s_axis_tvalid && s_axis_tready, "store write without accept")

endmodule

// ===== tb/row_softmax_core_test.sv =====
// ----------------------------------------------------------------------------
// row_softmax_core_test
// Drives rows of Q8.8 logits into the row softmax core and checks every
// probability word against a softmax predictor held in the bench.
// ----------------------------------------------------------------------------
module row_softmax_core_test import rsm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] prob;
        logic        last;
        logic        trunc;
    } t_prob;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // logit
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // prob
    logic        m_axis_tlast;
    logic        m_axis_tuser;   // truncated

    t_prob                 prob_fifo[$];
    logic signed [15:0]    row_buf[RSM_STORE_DEPTH];
    int                    row_cnt;
    logic signed [15:0]    row_peak;
    bit                    row_trunc;
    int                    err_cnt;
    int                    quiet_cnt;
    int                    rx_idle_cnt;
    bit                    idle_off;

    row_softmax_core dut (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [15:0] pow2_frac(input int idx);
        logic [15:0] lut[32] = '{
            16'd32768, 16'd32066, 16'd31379, 16'd30706,
            16'd30048, 16'd29405, 16'd28774, 16'd28158,
            16'd27554, 16'd26964, 16'd26386, 16'd25821,
            16'd25268, 16'd24726, 16'd24196, 16'd23678,
            16'd23170, 16'd22674, 16'd22188, 16'd21713,
            16'd21248, 16'd20792, 16'd20347, 16'd19910,
            16'd19484, 16'd19067, 16'd18658, 16'd18258,
            16'd17867, 16'd17484, 16'd17109, 16'd16742};
        return lut[idx];
    endfunction

    function automatic int unsigned exp_q15(input logic signed [15:0] x,
                                            input logic signed [15:0] mx);
        logic [15:0] d;
        logic [39:0] t;
        d = mx - x;
        t = 40'(d) * 40'd94548;
        if ((t >> 24) >= 16) return 0;
        return int'(pow2_frac(int'(t[23:19]))) >> int'(t >> 24);
    endfunction

    task automatic predict_logit(input logic [15:0] x, input bit last);
        int unsigned e[RSM_STORE_DEPTH];
        int unsigned sum;
        longint unsigned p;
        t_prob r;
        if (row_cnt < RSM_ROW_LEN) begin
            row_buf[row_cnt] = x;
            row_cnt++;
            if ($signed(x) > row_peak) row_peak = x;
        end else begin
            row_trunc = 1'b1;
        end
        if (!last) return;
        sum = 0;
        for (int i = 0; i < row_cnt; i++) begin
            e[i] = exp_q15(row_buf[i], row_peak);
            sum += e[i];
        end
        for (int i = 0; i < row_cnt; i++) begin
            p = (longint'(e[i]) * 32768 + sum / 2) / sum;
            r.prob = p[15:0];
            r.last = (i + 1 == row_cnt);
            r.trunc = row_trunc;
            prob_fifo.push_back(r);
        end
        row_cnt = 0;
        row_peak = -16'sd32768;
        row_trunc = 1'b0;
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_cnt++;
    endtask

    task automatic send_logit(input logic [15:0] x, input bit last);
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = x;
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_logit(x, last);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_row(input int n, input int lo, input int hi);
        for (int i = 0; i < n; i++)
            send_logit(16'($urandom_range(lo, hi) - 32768), i == n - 1);
    endtask

    task automatic wait_drained();
        while (prob_fifo.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (idle_off) begin
            rx_idle_cnt = 0;
            m_axis_tready <= 1'b1;
        end else if (rx_idle_cnt != 0) begin
            rx_idle_cnt = rx_idle_cnt - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            rx_idle_cnt = $urandom_range(1, 6) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_prob want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (prob_fifo.size() == 0) begin
                report("unexpected word", m_axis_tdata, -1);
            end else begin
                want = prob_fifo.pop_front();
                if (m_axis_tdata !== want.prob) report("prob", m_axis_tdata, want.prob);
                if (m_axis_tlast !== want.last) report("last", m_axis_tlast, want.last);
                if (m_axis_tuser !== want.trunc)
                    report("truncated", m_axis_tuser, want.trunc);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt > 20000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_extremes();
        send_logit(16'h7FFF, 1'b1);
        send_logit(16'h8000, 1'b0);
        send_logit(16'h7FFF, 1'b1);
        send_logit(16'h8000, 1'b0);
        send_logit(16'h8000, 1'b1);
        send_logit(16'h0000, 1'b0);
        send_logit(16'hFFFF, 1'b0);
        send_logit(16'h0100, 1'b0);
        send_logit(16'hF000, 1'b0);
        send_logit(16'h0AAA, 1'b0);
        send_logit(16'hF555, 1'b1);
    endtask

    task automatic test_flush_edge();
        // Differences close to where the shift reaches sixteen.
        send_logit(16'h0000, 1'b0);
        send_logit(16'hF4E8, 1'b0);
        send_logit(16'hF4E9, 1'b0);
        send_logit(16'hF4D0, 1'b1);
    endtask

    task automatic test_truncation();
        send_row(RSM_ROW_LEN + 2, 0, 65535);
        wait_drained();
    endtask

    task automatic test_random_rows();
        for (int r = 0; r < 4; r++) begin
            if ($urandom_range(0, 1)) send_row($urandom_range(1, 6), 0, 65535);
            else send_row($urandom_range(1, 6), 32000, 34000);
        end
    endtask

    task automatic test_no_idle();
        idle_off = 1'b1;
        for (int r = 0; r < 6; r++) send_row($urandom_range(1, 5), 31000, 34500);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        rx_idle_cnt = 0;
        idle_off = 1'b0;
        err_cnt = 0;
        quiet_cnt = 0;
        row_cnt = 0;
        row_peak = -16'sd32768;
        row_trunc = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_flush_edge();
        wait_drained();
        test_truncation();
        test_random_rows();
        test_no_idle();
        wait_drained();
        repeat (300) @(negedge i_clk);
        if (err_cnt == 0 && prob_fifo.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== row_softmax_core.f =====
+incdir+hdl
hdl/rsm_pkg.sv
hdl/rsm_front.sv
hdl/rsm_queue.sv
hdl/rsm_back.sv
hdl/row_softmax_core.sv
tb/row_softmax_core_test.sv
